// ===== sv/dtic_pkg.sv =====
// Package for the double-to-int modular converter: op codes, item types, constants.
// No dependencies.
`timescale 1ns / 1ps
package dtic_pkg;

    localparam int ExpBias  = 1023;
    localparam int FracBits = 52;

    typedef enum logic [2:0] {
        OP_I32_WRAP  = 3'd0,
        OP_U32_WRAP  = 3'd1,
        OP_U16_WRAP  = 3'd2,
        OP_I32_CHECK = 3'd3,
        OP_U32_CHECK = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] number_bits;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result;
        logic        ok;
    } out_item_t;

endpackage

// ===== sv/dtic_conv.sv =====
// Combinational conversion of one binary64 pattern to an integer result.
// Depends on dtic_pkg.
`timescale 1ns / 1ps
module dtic_conv (
    input  dtic_pkg::in_item_t  item,
    output dtic_pkg::out_item_t res
);
    import dtic_pkg::*;

    logic        neg;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [52:0] sig;
    logic [84:0] shifted;
    logic [6:0]  sh;
    logic [31:0] mag;
    logic [31:0] val;
    logic        finite;
    logic        frac_zero;

    assign neg       = item.number_bits[63];
    assign ex        = item.number_bits[62:52];
    assign frac      = item.number_bits[51:0];
    assign sig       = {1'b1, frac};
    assign finite    = (ex != 11'h7FF);
    assign frac_zero = (frac == '0);

    // Window position: value bits [83:52] are the integer part for ex in [bias, bias+32).
    assign sh      = 7'(ex - 11'(ExpBias));
    assign shifted = {32'd0, sig} << sh;

    always_comb
    begin
        if (ex < 11'(ExpBias) || ex >= 11'(ExpBias + 84))
            mag = '0;
        else
            mag = shifted[FracBits +: 32];
        val = neg ? 32'(32'd0 - mag) : mag;
        res = '{result: '0, ok: 1'b0};
        if (finite)
        begin
            unique case (item.op)
                OP_I32_WRAP, OP_U32_WRAP:
                    res = '{result: val, ok: 1'b1};
                OP_U16_WRAP:
                    res = '{result: {16'd0, val[15:0]}, ok: 1'b1};
                OP_I32_CHECK:
                    if (ex < 11'(ExpBias + 31) ||
                        (neg && ex == 11'(ExpBias + 31) && frac_zero))
                        res = '{result: val, ok: 1'b1};
                OP_U32_CHECK:
                    if ((!neg || (ex == '0 && frac_zero)) && ex < 11'(ExpBias + 32))
                        res = '{result: val, ok: 1'b1};
                default:
                    res = '{result: '0, ok: 1'b0};
            endcase
        end
    end
endmodule

// ===== sv/double_to_int_modular_convert_core.sv =====
// Top level of the double-to-int converter: input register, conversion, result register.
// Depends on dtic_pkg and dtic_conv.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive start high with in_item (op, number_bits) for one
//   cycle; the item is taken at that edge. busy is always low, so a new
//   item may be given every cycle.
//   Result channel: done pulses high for exactly one cycle with out_item
//   (result, ok). The receiver cannot stall; it must take the item then.
//   Path: the item goes through the input register, the conversion and
//   the result register, which drives done and out_item.
//   Throughput: one item per cycle, set by the single pass through the
//   conversion logic between the two registers.
//   Ops: int32 wrap, uint32 wrap, uint16 wrap, int32 checked, uint32 checked.
//   NaN/infinity and unused ops give result 0, ok 0.
//   Reset: rst_n clears the valid flags; items in flight are dropped and
//   done stays low until a new item passes through.
module double_to_int_modular_convert_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dtic_pkg::in_item_t  in_item,
    output logic                done,
    output dtic_pkg::out_item_t out_item
);
    import dtic_pkg::*;

    logic      in_vld_reg;
    in_item_t  in_reg;
    logic      out_vld_reg;
    out_item_t out_reg;
    out_item_t out_next;

    assign busy = 1'b0;

    dtic_conv u_conv (
        .item (in_reg),
        .res  (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            in_reg <= in_item;
        if (in_vld_reg)
            out_reg <= out_next;
    end

    assign done     = out_vld_reg;
    assign out_item = out_reg;
endmodule

// ===== sv/dtic_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on dtic_pkg and double_to_int_modular_convert_core.
`timescale 1ns / 1ps
module dtic_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input dtic_pkg::in_item_t  in_item,
    input logic                done,
    input dtic_pkg::out_item_t out_item
);
    import dtic_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done) else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2)) else $error("spurious result");
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && in_item.number_bits[62:52] == 11'h7FF |-> ##2 !out_item.ok
        && out_item.result == '0) else $error("non-finite gave ok");
    a_u16_range: assert property (@(posedge clk) disable iff (!rst_n)
        start && in_item.op == OP_U16_WRAP |-> ##2 out_item.result[31:16] == '0)
        else $error("uint16 high bits set");
endmodule

bind double_to_int_modular_convert_core dtic_checker u_dtic_checker (.*);

// ===== tb/sv/double_to_int_modular_convert_core_tb.sv =====
// Testbench for double_to_int_modular_convert_core: directed and random doubles in every op.
// Depends on dtic_pkg and the core RTL; self-checking through a small scoreboard class.
`timescale 1ns / 1ps
module double_to_int_modular_convert_core_tb;
    import dtic_pkg::*;

    // Expected conversion results, oldest first.
    class conv_scoreboard;
        out_item_t pending[$];
        int        errors;

        // Truncated magnitude of the number, low 32 bits.
        function automatic logic [31:0] trunc_mag(logic [10:0] ex, logic [51:0] frac);
            logic [52:0] sig;
            int          sh;
            sig = {1'b1, frac};
            if (ex < ExpBias)
                return 32'd0;
            sh = int'(ex) - (ExpBias + FracBits);
            if (sh < 0)
                return 32'(sig >> (-sh));
            if (sh >= 32)
                return 32'd0;
            return 32'({11'd0, sig} << sh);
        endfunction

        function automatic void note_item(in_item_t it);
            out_item_t   exp_item;
            logic        neg;
            logic [10:0] ex;
            logic [51:0] frac;
            logic [31:0] val;
            neg  = it.number_bits[63];
            ex   = it.number_bits[62:52];
            frac = it.number_bits[51:0];
            exp_item = '0;
            if (ex != 11'h7FF) begin
                val = trunc_mag(ex, frac);
                if (neg)
                    val = -val;
                case (it.op)
                    OP_I32_WRAP, OP_U32_WRAP:
                    begin
                        exp_item.result = val;
                        exp_item.ok = 1'b1;
                    end
                    OP_U16_WRAP:
                    begin
                        exp_item.result = {16'd0, val[15:0]};
                        exp_item.ok = 1'b1;
                    end
                    OP_I32_CHECK:
                        if (ex < ExpBias + 31 || (neg && ex == ExpBias + 31 && frac == 0))
                        begin
                            exp_item.result = val;
                            exp_item.ok = 1'b1;
                        end
                    OP_U32_CHECK:
                        if ((!neg || (ex == 0 && frac == 0)) && ex < ExpBias + 32)
                        begin
                            exp_item.result = val;
                            exp_item.ok = 1'b1;
                        end
                    default: ;
                endcase
            end
            pending.push_back(exp_item);
        endfunction

        function automatic void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $error("unexpected result %h ok %b", got.result, got.ok);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.result !== want.result) begin
                $error("result: expected %h, actual %h", want.result, got.result);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $error("ok: expected %b, actual %b", want.ok, got.ok);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  in_item;
    logic      done;
    out_item_t out_item;

    conv_scoreboard sb;
    int             send_gap_pct;
    longint         cycle_count;

    double_to_int_modular_convert_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .out_item(out_item)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results are taken at the edge that ends the strobe cycle.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
            sb.check_result(out_item);
        if (cycle_count > 200000) begin
            $display("double_to_int_modular_convert_core_tb: FAIL");
            $finish;
        end
    end

    // Present one item; hold start until it is taken (busy low at the edge).
    // Random idle cycles go in front of the item, so start stays up between
    // back-to-back items without a drop-and-raise within one step.
    task automatic send_item(logic [2:0] op, logic [63:0] bits);
        in_item_t it;
        it.op = op;
        it.number_bits = bits;
        if ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (busy);
        sb.note_item(it);
    endtask

    // Exponent biased toward the interesting band around 2^-2 .. 2^70.
    function automatic logic [63:0] rand_double();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1:    b[62:52] = 11'($urandom_range(0, 11'h7FF));
            2:       b[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
            3:       b[62:52] = 11'(ExpBias + 31 + $urandom_range(0, 1));
            default: b[62:52] = 11'($urandom_range(ExpBias - 2, ExpBias + 70));
        endcase
        if ($urandom_range(7) == 0)
            b[51:0] = $urandom_range(1) ? 52'd0 : '1;
        return b;
    endfunction

    initial
    begin
        logic [63:0] dir[$];
        sb = new();
        cycle_count = 0;
        send_gap_pct = 9;
        start = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zeros, denormals, below one, values around 2^31 and around 2^32, huge, inf, NaN.
        dir = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
                64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                64'h41E0_0000_0000_0000, 64'hC1E0_0000_0000_0000,
                64'hC1E0_0000_0010_0000, 64'h41DF_FFFF_FFC0_0000,
                64'h41EF_FFFF_FFE0_0000, 64'h41F0_0000_0000_0000,
                64'h7FEF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                64'h4330_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
        foreach (dir[i])
            send_item(3'($urandom_range(0, 7)), dir[i]);
        for (int o = 0; o < 8; o++)
            send_item(3'(o), 64'hC0F0_0001_0000_0000);

        for (int n = 0; n < 550; n++) begin
            if (n == 180)
                send_gap_pct = 57;
            else if (n == 360)
                send_gap_pct = 0;
            send_item($urandom_range(9) == 0 ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4)),
                      rand_double());
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("double_to_int_modular_convert_core_tb: PASS");
        else
            $display("double_to_int_modular_convert_core_tb: FAIL");
        $finish;
    end
endmodule
